/* rtl/esl_pkg.sv */
// Shared types and constants for the eased slew limiter.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package esl_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd3;

  // Curve modes; any code other than these two shapes as quadratic
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_SCURVE = 2'd1;

  // Reset values of the configuration registers
  localparam int STEP_SIZE_RST  = 256;
  localparam int FULL_SCALE_RST = 32767;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_NORM,
    S_DIV,
    S_OPND,
    S_SQUARE,
    S_SHAPE,
    S_SCALE,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic step;
    logic norm;
    logic div;
    logic div_first;
    logic opnd;
    logic square;
    logic shape;
    logic scale;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bypass;
  } status_t;

endpackage

`default_nettype wire

/* rtl/esl_intf.sv */
// Valid/ready channel interfaces: input sample, result and configuration write.
// Depends on esl_pkg for the register index width.
`default_nettype none

interface esl_sample_if #(parameter int VALUE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] target;

  modport source (output valid, output target, input ready);
  modport sink   (input valid, input target, output ready);
endinterface

interface esl_result_if #(parameter int VALUE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] eased_value;
  logic signed [VALUE_WIDTH-1:0] ramp_value;
  logic                          at_target;
  logic                          over_range;

  modport source (output valid, output eased_value, output ramp_value,
                  output at_target, output over_range, input ready);
  modport sink   (input valid, input eased_value, input ramp_value,
                  input at_target, input over_range, output ready);
endinterface

interface esl_cfg_if
  import esl_pkg::*;
#(parameter int VALUE_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [VALUE_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/eased_slew_limiter_unit.sv */
// Top level of the eased slew limiter: controller, datapath and channel glue.
// Depends on esl_pkg, esl_intf, esl_ctrl and esl_datapath.
`default_nettype none

// Each accepted target moves a ramp position toward it by step_size (snapping
// onto it when closer than one step), then shapes the ramp by curve_mode:
// bypass, S-curve or quadratic, normalizing by full_scale. In the curve modes
// an item passes from accept through ramp step, normalize, the restoring
// divider that forms one quotient bit per cycle, operand select, square,
// shaping, rescale and result load; bypass mode goes from normalize straight
// to result load. One item is in flight at a time; a new target is taken while
// the previous result waits in the output register. Configuration writes are
// taken in any cycle, must only be issued while the block is idle, and writing
// start_value also loads the ramp.
module eased_slew_limiter_unit
  import esl_pkg::*;
#(
  parameter int VALUE_WIDTH     = 16,
  parameter int CURVE_FRAC_BITS = 16
) (
  input wire logic    clk,
  input wire logic    rst,
  esl_cfg_if.sink     cfg,
  esl_sample_if.sink  sample,
  esl_result_if.source result
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign cfg.ready    = 1'b1;
  assign sample.ready = in_ready;
  assign result.valid = out_valid;

  esl_ctrl #(
    .CURVE_FRAC_BITS(CURVE_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(result.ready),
    .status   (status),
    .cmd      (cmd)
  );

  esl_datapath #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .CURVE_FRAC_BITS(CURVE_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .target     (sample.target),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .eased_value(result.eased_value),
    .ramp_value (result.ramp_value),
    .at_target  (result.at_target),
    .over_range (result.over_range)
  );

`ifndef SYNTH
  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result register loaded while a beat is pending");

  // A loaded result shows up as a valid beat
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result.valid)
    else $error("loaded result not presented");

  // One item at a time: busy right after an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("second beat accepted while an item is in flight");

  // Bypass results never carry the clamp flag
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && status.bypass) |=> !result.over_range)
    else $error("over_range set in bypass mode");
`endif

endmodule

`default_nettype wire

/* rtl/esl_ctrl.sv */
// Sequencing state machine: accept, ramp step, normalize, divide, shape, deliver.
// Depends on esl_pkg for state_t, cmd_t and status_t.
`default_nettype none

module esl_ctrl
  import esl_pkg::*;
#(
  parameter int CURVE_FRAC_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int F  = CURVE_FRAC_BITS;
  localparam int CW = $clog2(F + 1);

  state_t        state, state_next;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_STEP;
      S_STEP:   state_next = S_NORM;
      S_NORM:   state_next = status.bypass ? S_DONE : S_DIV;
      S_DIV:    if (cnt == CW'(F)) state_next = S_OPND;
      S_OPND:   state_next = S_SQUARE;
      S_SQUARE: state_next = S_SHAPE;
      S_SHAPE:  state_next = S_SCALE;
      S_SCALE:  state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    in_ready      = (state == S_IDLE);
    cmd.load_item = in_ready && in_valid;
    cmd.step      = (state == S_STEP);
    cmd.norm      = (state == S_NORM);
    cmd.div       = (state == S_DIV);
    cmd.div_first = (state == S_DIV) && (cnt == '0);
    cmd.opnd      = (state == S_OPND);
    cmd.square    = (state == S_SQUARE);
    cmd.shape     = (state == S_SHAPE);
    cmd.scale     = (state == S_SCALE);
    cmd.load_out  = (state == S_DONE) && out_free;
  end

  // State, divide step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/esl_datapath.sv */
// Datapath: configuration registers, ramp position, restoring divider, curve
// multiplier stages and the result register. Depends on esl_pkg.
`default_nettype none

module esl_datapath
  import esl_pkg::*;
#(
  parameter int VALUE_WIDTH     = 16,
  parameter int CURVE_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cmd_t                          cmd,
  output status_t                            status,
  input  wire logic signed [VALUE_WIDTH-1:0] target,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]        cfg_data,
  output logic signed [VALUE_WIDTH-1:0]      eased_value,
  output logic signed [VALUE_WIDTH-1:0]      ramp_value,
  output logic                               at_target,
  output logic                               over_range
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = CURVE_FRAC_BITS;
  localparam int MW = W - 1;
  localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};

  // Configuration and ramp state
  logic [MW-1:0]       step_size;
  logic [MW-1:0]       full_scale;
  logic [1:0]          curve_mode;
  logic signed [W-1:0] ramp;

  // Working registers
  logic signed [W-1:0] target_q;
  logic                at_q, over_q, neg_q;
  logic [W-1:0]        rem;
  logic [F:0]          quo;
  logic [F:0]          x_q, op_q, f_q;
  logic [2*F+1:0]      prod_q;
  logic [MW-1:0]       y_q;

  // Combinational helpers
  logic signed [W:0]   diff;
  logic [W:0]          gap;
  logic signed [W-1:0] ramp_next;
  logic [W-1:0]        mag;
  logic [W:0]          trial;
  logic                ge;
  logic [W:0]          trial_sub;
  logic [F:0]          x_eff;
  logic                scurve;
  logic [F+MW:0]       scale_prod;
  logic [W-1:0]        y_ext;

  assign status.bypass = (curve_mode == MODE_BYPASS);
  assign scurve        = (curve_mode == MODE_SCURVE);

  // Ramp step toward target; snap when the gap is under one step
  always_comb begin
    diff = {target_q[W-1], target_q} - {ramp[W-1], ramp};
    gap  = diff[W] ? (W+1)'(-diff) : diff;
    if (gap < {2'b00, step_size}) begin
      ramp_next = target_q;
    end else if (target_q > ramp) begin
      ramp_next = ramp + $signed({1'b0, step_size});
    end else begin
      ramp_next = ramp - $signed({1'b0, step_size});
    end
  end

  assign mag = ramp[W-1] ? W'(-ramp) : ramp;

  // One restoring divide step: compare, subtract, shift in a quotient bit
  assign trial     = cmd.div_first ? {1'b0, rem} : {rem, 1'b0};
  assign ge        = (trial >= {2'b00, full_scale});
  assign trial_sub = trial - {2'b00, full_scale};

  // Clamp above full scale; zero full scale with zero magnitude gives zero
  always_comb begin
    if (over_q) begin
      x_eff = ONE;
    end else if (full_scale == '0) begin
      x_eff = '0;
    end else begin
      x_eff = quo;
    end
  end

  assign scale_prod = f_q * full_scale;
  assign y_ext      = {1'b0, y_q};

  // Configuration writes and ramp update
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= MW'(STEP_SIZE_RST);
      full_scale <= MW'(FULL_SCALE_RST);
      curve_mode <= MODE_BYPASS;
      ramp       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_SIZE:   step_size  <= cfg_data[MW-1:0];
          REG_FULL_SCALE:  full_scale <= cfg_data[MW-1:0];
          REG_CURVE_MODE:  curve_mode <= cfg_data[1:0];
          REG_START_VALUE: ramp       <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.step) begin
        ramp <= ramp_next;
      end
    end
  end

  // Item pipeline registers, advanced one command at a time
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      target_q <= target;
    end
    if (cmd.norm) begin
      at_q   <= (ramp == target_q);
      over_q <= (mag > {1'b0, full_scale});
      neg_q  <= ramp[W-1];
      rem    <= mag;
    end
    if (cmd.div) begin
      rem <= ge ? trial_sub[W-1:0] : trial[W-1:0];
      quo <= {quo[F-1:0], ge};
    end
    if (cmd.opnd) begin
      x_q  <= x_eff;
      op_q <= (scurve && (x_eff >= HALF)) ? (ONE - x_eff) : x_eff;
    end
    if (cmd.square) begin
      prod_q <= op_q * op_q;
    end
    if (cmd.shape) begin
      if (!scurve) begin
        f_q <= prod_q[2*F:F];
      end else if (x_q < HALF) begin
        f_q <= prod_q[2*F-1:F-1];
      end else begin
        f_q <= ONE - prod_q[2*F-1:F-1];
      end
    end
    if (cmd.scale) begin
      y_q <= scale_prod[F +: MW];
    end
    if (cmd.load_out) begin
      ramp_value <= ramp;
      at_target  <= at_q;
      if (status.bypass) begin
        eased_value <= ramp;
        over_range  <= 1'b0;
      end else begin
        eased_value <= neg_q ? W'(-y_ext) : y_ext;
        over_range  <= over_q;
      end
    end
  end

endmodule

`default_nettype wire

/* test/eased_slew_limiter_unit_tb.sv */
// Self-checking bench for eased_slew_limiter_unit: ramp stepping, curve shaping and flags.
// Predicts every result in-bench from the register settings; depends on esl_pkg and esl_intf.
`default_nettype none

module eased_slew_limiter_unit_tb;
  import esl_pkg::*;

  localparam int VW = 16;
  localparam int FB = 16;
  localparam int VMAX = 2 ** (VW - 1) - 1;
  localparam int VMIN = -(2 ** (VW - 1));
  localparam longint unsigned FX_ONE  = 64'd1 << FB;
  localparam longint unsigned FX_HALF = 64'd1 << (FB - 1);

  // Mode codes not named in the package; the spare code shapes as quadratic
  localparam logic [1:0] MODE_QUADRATIC = 2'd2;
  localparam logic [1:0] MODE_QUAD_ALT  = 2'd3;

  localparam int IDLE_PCT      = 17;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic signed [VW-1:0] eased;
    logic signed [VW-1:0] ramp;
    logic                 at_tgt;
    logic                 over;
  } slew_result_t;

  logic clk = 1'b0;
  logic rst;

  esl_cfg_if    #(.VALUE_WIDTH(VW)) cfg_if ();
  esl_sample_if #(.VALUE_WIDTH(VW)) smp_if ();
  esl_result_if #(.VALUE_WIDTH(VW)) res_if ();

  eased_slew_limiter_unit #(
    .VALUE_WIDTH    (VW),
    .CURVE_FRAC_BITS(FB)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_if),
    .sample(smp_if),
    .result(res_if)
  );

  // 10-unit clock period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted register and ramp state
  logic [VW-2:0]        step_sz;
  logic [VW-2:0]        full_sc;
  logic [1:0]           mode;
  logic signed [VW-1:0] ramp_pos;

  slew_result_t shaped_q[$];

  int  errors;
  int  n_sent;
  int  n_checked;
  int  n_over;
  int  n_at;
  int  n_settings;
  bit  idle_on;

  // Advance the ramp toward tgt and shape it per the current mode
  function automatic slew_result_t slew_and_shape(input logic signed [VW-1:0] tgt);
    logic signed [VW+1:0] diff;
    logic [VW+1:0]        gap;
    longint               rp;
    longint unsigned      mag;
    longint unsigned      x;
    longint unsigned      f;
    longint unsigned      d;
    longint unsigned      y;
    logic [VW-1:0]        ylo;
    slew_result_t         r;
    diff = tgt - ramp_pos;
    gap  = (diff < 0) ? -diff : diff;
    if (gap < step_sz) begin
      ramp_pos = tgt;
    end else if (tgt > ramp_pos) begin
      ramp_pos = ramp_pos + step_sz;
    end else begin
      ramp_pos = ramp_pos - step_sz;
    end
    r.ramp   = ramp_pos;
    r.at_tgt = (ramp_pos == tgt);
    r.over   = 1'b0;
    if (mode == MODE_BYPASS) begin
      r.eased = ramp_pos;
    end else begin
      rp  = ramp_pos;
      mag = (rp < 0) ? -rp : rp;
      // Normalize, clamping above full scale
      if (mag > full_sc) begin
        x      = FX_ONE;
        r.over = 1'b1;
      end else if (full_sc == 0) begin
        x = 0;
      end else begin
        x = (mag << FB) / full_sc;
      end
      if (mode == MODE_SCURVE) begin
        if (x < FX_HALF) begin
          f = (x * x) >> (FB - 1);
        end else begin
          d = FX_ONE - x;
          f = FX_ONE - ((d * d) >> (FB - 1));
        end
      end else begin
        f = (x * x) >> FB;
      end
      // Restore scale and sign
      y       = (f * full_sc) >> FB;
      ylo     = y[VW-1:0];
      r.eased = (rp < 0) ? -ylo : ylo;
    end
    return r;
  endfunction

  // Target mix: random, near the ramp, on the ramp, extremes, around full scale
  function automatic logic signed [VW-1:0] pick_target();
    int            sel;
    int            lim;
    int            v;
    logic [VW-1:0] raw;
    sel = $urandom_range(0, 99);
    raw = $urandom;
    if (sel < 40) begin
      v = $signed(raw);
    end else if (sel < 65) begin
      lim = 2 * step_sz + 3;
      v   = ramp_pos + int'($urandom_range(0, 2 * lim)) - lim;
    end else if (sel < 75) begin
      v = ramp_pos;
    end else if (sel < 85) begin
      case ($urandom_range(0, 3))
        0:       v = VMAX;
        1:       v = VMIN;
        2:       v = 0;
        default: v = -int'(full_sc);
      endcase
    end else begin
      v = int'(full_sc) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    if (v > VMAX) v = VMAX;
    if (v < VMIN) v = VMIN;
    return v[VW-1:0];
  endfunction

  // Register value with its extremes weighted up and all bits exercised
  function automatic logic [VW-2:0] pick_reg15(input int zero_pct);
    int            sel;
    logic [VW-2:0] raw;
    sel = $urandom_range(0, 99);
    raw = $urandom;
    if (sel < zero_pct) return '0;
    if (sel < zero_pct + 8) return '1;
    if (sel < zero_pct + 16) return 1;
    return raw >> $urandom_range(0, VW - 2);
  endfunction

  // One configuration beat; valid stays high for a following beat
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [VW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_STEP_SIZE:   step_sz  = val[VW-2:0];
      REG_FULL_SCALE:  full_sc  = val[VW-2:0];
      REG_CURVE_MODE:  mode     = val[1:0];
      REG_START_VALUE: ramp_pos = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [VW-2:0] s, input logic [VW-2:0] fs,
                                input logic [1:0] m, input logic [VW-1:0] start);
    cfg_beat(REG_STEP_SIZE, {1'b0, s});
    cfg_beat(REG_FULL_SCALE, {1'b0, fs});
    cfg_beat(REG_CURVE_MODE, {{(VW-2){1'b0}}, m});
    cfg_beat(REG_START_VALUE, start);
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // Send one target beat, with random gaps ahead of it
  task automatic send_target(input logic signed [VW-1:0] t);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid  <= 1'b1;
    smp_if.target <= t;
    do @(posedge clk); while (smp_if.ready !== 1'b1);
    shaped_q.push_back(slew_and_shape(t));
    n_sent++;
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_target(VMAX);
    send_target(VMIN);
    send_target(0);
  endtask

  // Full-range swings with the largest step, bypass
  task automatic test_bypass_extremes();
    drain_results();
    apply_settings('1, '1, MODE_BYPASS, VMIN);
    send_target(VMAX);
    send_target(VMAX);
    send_target(VMAX);
    send_target(VMIN);
  endtask

  // S-curve, quadratic and the spare code over both halves of the curve
  task automatic test_curve_modes();
    logic [1:0] modes [3];
    modes = '{MODE_SCURVE, MODE_QUADRATIC, MODE_QUAD_ALT};
    foreach (modes[i]) begin
      drain_results();
      apply_settings(8192, '1, modes[i], 0);
      send_target(VMAX);
      send_target(VMAX);
      send_target(VMIN);
    end
  endtask

  // Exact half point, exact full scale, then just over it
  task automatic test_full_scale_edges();
    drain_results();
    apply_settings(1, 2, MODE_SCURVE, 0);
    send_target(1);
    send_target(3);
    send_target(5);
  endtask

  // Zero step holds the ramp; zero full scale clamps any nonzero magnitude
  task automatic test_zero_step();
    drain_results();
    apply_settings(0, 0, MODE_QUADRATIC, 0);
    send_target(0);
    drain_results();
    apply_settings(0, 0, MODE_QUADRATIC, 5);
    send_target(100);
    send_target(5);
    drain_results();
    apply_settings(0, 0, MODE_SCURVE, -7);
    send_target(-7);
  endtask

  // Phases of held and wandering targets under changing settings
  task automatic test_random_phases();
    int                   left;
    int                   reps;
    logic signed [VW-1:0] t;
    logic [VW-2:0]        s;
    logic [VW-2:0]        fs;
    logic [1:0]           m;
    logic [VW-1:0]        sv;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          s  = '1;
          fs = '1;
          m  = MODE_SCURVE;
        end
        1: begin
          s  = 1;
          fs = 1;
          m  = MODE_QUADRATIC;
        end
        default: begin
          s  = pick_reg15(6);
          fs = pick_reg15(3);
          m  = $urandom_range(0, 3);
        end
      endcase
      sv      = $urandom;
      idle_on = (p != 2);
      apply_settings(s, fs, m, sv);
      left = PHASE_ITEMS;
      while (left > 0) begin
        t    = pick_target();
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          if (left > 0) begin
            send_target(t);
            left--;
          end
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Result sink: check each beat against the oldest prediction, stall at random
  initial begin
    slew_result_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        if (shaped_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: eased %0d ramp %0d",
                                     res_if.eased_value, res_if.ramp_value);
        end else begin
          want = shaped_q.pop_front();
          n_checked++;
          if (want.over) n_over++;
          if (want.at_tgt) n_at++;
          if (res_if.eased_value !== want.eased || res_if.ramp_value !== want.ramp ||
              res_if.at_target !== want.at_tgt || res_if.over_range !== want.over) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result %0d (expected/actual):", n_checked);
              $display("  eased %0d/%0d ramp %0d/%0d at_target %0b/%0b over_range %0b/%0b",
                       want.eased, res_if.eased_value, want.ramp, res_if.ramp_value,
                       want.at_tgt, res_if.at_target, want.over, res_if.over_range);
            end
          end
        end
      end
      res_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", shaped_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int wait_cnt;
    rst           <= 1'b1;
    smp_if.valid  <= 1'b0;
    smp_if.target <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_STEP_SIZE;
    cfg_if.data   <= '0;
    idle_on    = 1'b1;
    errors     = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_over     = 0;
    n_at       = 0;
    n_settings = 0;
    step_sz    = STEP_SIZE_RST;
    full_sc    = FULL_SCALE_RST;
    mode       = MODE_BYPASS;
    ramp_pos   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_bypass_extremes();
    test_curve_modes();
    test_full_scale_edges();
    test_zero_step();
    test_random_phases();

    // Let the last results drain, then watch for stray beats
    smp_if.valid <= 1'b0;
    wait_cnt = 0;
    while (shaped_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    if (shaped_q.size() != 0) begin
      errors += shaped_q.size();
      $display("%0d predicted results never arrived", shaped_q.size());
    end

    $display("Sent %0d targets under %0d register settings, checked %0d results.",
             n_sent, n_settings, n_checked);
    $display("Of those, %0d were clamped over range and %0d landed on target.", n_over, n_at);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
